FILE: src/rpi_pkg.sv
package rpi_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_PROFILE_SELECT = 2'd0;
	localparam logic [1:0] REG_MANUAL_SETPOINT = 2'd1;
	localparam logic [1:0] REG_ROOM_TEMPERATURE = 2'd2;

	// Profile selection codes
	localparam logic [1:0] SEL_MANUAL = 2'd0;
	localparam logic [1:0] SEL_PROF1 = 2'd1;
	localparam logic [1:0] SEL_PROF2 = 2'd2;
	localparam logic [1:0] SEL_NONE = 2'd3;

	// Register reset values
	localparam logic [1:0] RST_PROFILE_SELECT = SEL_MANUAL;
	localparam logic [12:0] RST_MANUAL_SETPOINT = 13'd400;
	localparam logic [12:0] RST_ROOM_TEMPERATURE = 13'd400;

	localparam int PROF_POINTS = 5;
	localparam logic [12:0] TEMP_MAX = 13'd8191;

	// Breakpoint ROM, time in 1/16 s, temperature in 1/16 C
	localparam logic [15:0] PT_TIME [2][PROF_POINTS] = '{
		'{16'd0, 16'd1440, 16'd2640, 16'd3600, 16'd4320},
		'{16'd0, 16'd1440, 16'd2880, 16'd3600, 16'd4320}
	};
	localparam logic [12:0] PT_TEMP [2][PROF_POINTS] = '{
		'{13'd0, 13'd2400, 13'd2800, 13'd3920, 13'd0},
		'{13'd0, 13'd2400, 13'd2880, 13'd3680, 13'd0}
	};
	localparam logic PT_AT_ROOM [2][PROF_POINTS] = '{
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1}
	};

	// Per segment: twice the time span, and floor(2^26 / that)
	localparam int RECIP_SHIFT = 26;
	localparam logic [11:0] SEG_D2 [2][PROF_POINTS-1] = '{
		'{12'd2880, 12'd2400, 12'd1920, 12'd1440},
		'{12'd2880, 12'd2880, 12'd1440, 12'd1440}
	};
	localparam logic [15:0] SEG_RECIP [2][PROF_POINTS-1] = '{
		'{16'd23301, 16'd27962, 16'd34952, 16'd46603},
		'{16'd23301, 16'd23301, 16'd46603, 16'd46603}
	};

	// Result of the segment search for one time sample
	typedef struct packed {
		logic bypass;
		logic done;
		logic [12:0] temp;
		logic prof;
		logic [1:0] seg;
		logic [10:0] dt;
		logic [12:0] y0;
		logic [14:0] dy;
	} seg_info_t;

	// Control carried alongside the interpolation arithmetic
	typedef struct packed {
		logic bypass;
		logic done;
		logic [12:0] temp;
		logic prof;
		logic [1:0] seg;
		logic [12:0] y0;
	} ctl_t;

	function automatic logic [12:0] pt_temp(input logic prof, input logic [2:0] idx,
			input logic [12:0] room);
		return PT_AT_ROOM[prof][idx] ? room : PT_TEMP[prof][idx];
	endfunction

endpackage

FILE: src/reflow_profile_interpolator.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata[15:0] elapsed_time
// m_*       out  m_tvalid/m_tready   m_tdata[12:0] setpoint_temp, m_tuser profile_done
// cfg_*     in   cfg_we              cfg_index register, cfg_data value
//
// Six register stages: segment search, delta multiply, offset add, reciprocal
// multiply, remainder multiply, correct and clamp. One transaction per cycle
// is accepted unless m_tready stalls; the multipliers set the stage depth.
// arst_n clears the stage valid bits and loads the register reset values.
// A stall on m_tready backs up stage by stage; s_tready drops only when every
// stage holds a transaction.
module reflow_profile_interpolator #(
	parameter int MAX_BREAKPOINTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] elapsed_time
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [12:0] setpoint_temp, [15:13] zero
	output logic        m_tuser,   // [0] profile_done
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);
	import rpi_pkg::*;

	localparam int NPTS = (MAX_BREAKPOINTS < PROF_POINTS) ? MAX_BREAKPOINTS : PROF_POINTS;

	logic [1:0]  profile_select_q;
	logic [12:0] manual_setpoint_q;
	logic [12:0] room_temperature_q;

	seg_info_t   info_c;
	seg_info_t   info_s1;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic        en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	ctl_t        ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [24:0] num_s2;
	logic [25:0] m_s3, m_s4, m_s5;
	logic [13:0] qhat_s4, qhat_s5;
	logic [25:0] qd_s5;
	logic [12:0] temp_s6;
	logic        done_s6;

	logic signed [26:0] num_c;
	logic [11:0] d2_s2;
	logic [26:0] m_c;
	logic [41:0] prod_c;
	logic [25:0] qd_c;
	logic [11:0] d2_s5;
	logic [25:0] rem_c;
	logic [13:0] q_c;
	logic [15:0] res_c;
	logic [12:0] temp_c;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_select_q <= RST_PROFILE_SELECT;
			manual_setpoint_q <= RST_MANUAL_SETPOINT;
			room_temperature_q <= RST_ROOM_TEMPERATURE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROFILE_SELECT: profile_select_q <= cfg_data[1:0];
				REG_MANUAL_SETPOINT: manual_setpoint_q <= cfg_data;
				REG_ROOM_TEMPERATURE: room_temperature_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or the next one advances
	assign en_s6 = !vld_s6 || m_tready;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// Stage 1: segment search
	rpi_seg_find #(
		.NPTS(NPTS)
	) u_seg_find (
		.elapsed_time    (s_tdata),
		.profile_select  (profile_select_q),
		.manual_setpoint (manual_setpoint_q),
		.room_temperature(room_temperature_q),
		.info            (info_c)
	);

	always_ff @(posedge clk) begin
		if (en_s1) info_s1 <= info_c;
	end

	// Stage 2: temperature delta times time offset
	assign num_c = $signed(info_s1.dy) * $signed({1'b0, info_s1.dt});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			num_s2 <= num_c[24:0];
			ctl_s2.bypass <= info_s1.bypass;
			ctl_s2.done <= info_s1.done;
			ctl_s2.temp <= info_s1.temp;
			ctl_s2.prof <= info_s1.prof;
			ctl_s2.seg <= info_s1.seg;
			ctl_s2.y0 <= info_s1.y0;
		end
	end

	// Stage 3: rounding term plus offset that keeps the dividend positive
	assign d2_s2 = SEG_D2[ctl_s2.prof][ctl_s2.seg];
	assign m_c = {num_s2[24], num_s2, 1'b0} + {16'd0, d2_s2[11:1]} + {2'b00, d2_s2, 13'd0};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			m_s3 <= m_c[25:0];
			ctl_s3 <= ctl_s2;
		end
	end

	// Stage 4: quotient estimate by reciprocal
	assign prod_c = m_s3 * SEG_RECIP[ctl_s3.prof][ctl_s3.seg];

	always_ff @(posedge clk) begin
		if (en_s4) begin
			qhat_s4 <= prod_c[RECIP_SHIFT+13:RECIP_SHIFT];
			m_s4 <= m_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// Stage 5: estimate times divisor
	assign qd_c = qhat_s4 * SEG_D2[ctl_s4.prof][ctl_s4.seg];

	always_ff @(posedge clk) begin
		if (en_s5) begin
			qd_s5 <= qd_c;
			qhat_s5 <= qhat_s4;
			m_s5 <= m_s4;
			ctl_s5 <= ctl_s4;
		end
	end

	// Stage 6: correct the estimate by one, remove offset, clamp
	assign d2_s5 = SEG_D2[ctl_s5.prof][ctl_s5.seg];
	assign rem_c = m_s5 - qd_s5;
	assign q_c = qhat_s5 + {13'd0, (rem_c >= {14'd0, d2_s5})};
	assign res_c = {3'b000, ctl_s5.y0} + {2'b00, q_c} - 16'd8192;

	always_comb begin
		if (res_c[15]) begin
			temp_c = 13'd0;
		end else if (res_c > {3'b000, TEMP_MAX}) begin
			temp_c = TEMP_MAX;
		end else begin
			temp_c = res_c[12:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			temp_s6 <= ctl_s5.bypass ? ctl_s5.temp : temp_c;
			done_s6 <= ctl_s5.done;
		end
	end

	assign m_tvalid = vld_s6;
	assign m_tdata = {3'b000, temp_s6};
	assign m_tuser = done_s6;

endmodule

FILE: src/rpi_seg_find.sv
module rpi_seg_find #(
	parameter int NPTS = 5
) (
	input  logic [15:0]           elapsed_time,
	input  logic [1:0]            profile_select,
	input  logic [12:0]           manual_setpoint,
	input  logic [12:0]           room_temperature,
	output rpi_pkg::seg_info_t    info
);
	import rpi_pkg::*;

	localparam logic [2:0] LAST_IDX = 3'(NPTS - 1);

	logic        prof;
	logic [2:0]  hit_idx;
	logic [2:0]  lo_idx;
	logic        found;
	logic [15:0] dt_full;
	logic [12:0] y0;
	logic [12:0] y1;

	assign prof = (profile_select == SEL_PROF2);

	// Find the first breakpoint later than the sample time
	always_comb begin
		hit_idx = 3'd0;
		for (int i = NPTS - 1; i >= 1; i--) begin
			if (elapsed_time < PT_TIME[prof][i]) begin
				hit_idx = 3'(i);
			end
		end
	end

	assign found = (hit_idx != 3'd0);
	assign lo_idx = found ? hit_idx - 3'd1 : 3'd0;
	assign dt_full = elapsed_time - PT_TIME[prof][lo_idx];
	assign y0 = pt_temp(prof, lo_idx, room_temperature);
	assign y1 = pt_temp(prof, hit_idx, room_temperature);

	// Decode the selection into bypass or interpolation
	always_comb begin
		info.bypass = 1'b1;
		info.done = 1'b1;
		info.temp = room_temperature;
		info.prof = prof;
		info.seg = lo_idx[1:0];
		info.dt = dt_full[10:0];
		info.y0 = y0;
		info.dy = {2'b00, y1} - {2'b00, y0};
		unique case (profile_select) inside
			SEL_MANUAL: begin
				info.done = 1'b0;
				info.temp = manual_setpoint;
			end
			SEL_PROF1, SEL_PROF2: begin
				if (found) begin
					info.bypass = 1'b0;
					info.done = 1'b0;
				end else begin
					info.temp = pt_temp(prof, LAST_IDX, room_temperature);
				end
			end
			SEL_NONE: begin
				info.temp = room_temperature;
			end
			default: begin
				info.temp = room_temperature;
			end
		endcase
	end

endmodule

FILE: src/rpi_checker.sv
module rpi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        cfg_we,
	input logic [1:0]  cfg_index,
	input logic [12:0] cfg_data
);
	import rpi_pkg::*;

	logic [1:0]  sel_q;
	logic [12:0] manual_q;
	logic [12:0] room_q;

	// Track the configuration from the write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= RST_PROFILE_SELECT;
			manual_q <= RST_MANUAL_SETPOINT;
			room_q <= RST_ROOM_TEMPERATURE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROFILE_SELECT: sel_q <= cfg_data[1:0];
				REG_MANUAL_SETPOINT: manual_q <= cfg_data;
				REG_ROOM_TEMPERATURE: room_q <= cfg_data;
				default: ;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while output side is free");

	a_manual: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sel_q == SEL_MANUAL |-> !m_tuser && m_tdata == {3'b000, manual_q})
		else $error("manual result mismatch");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && sel_q == SEL_NONE |-> m_tuser && m_tdata == {3'b000, room_q})
		else $error("invalid selection result mismatch");

endmodule

bind reflow_profile_interpolator rpi_checker u_rpi_checker (.*);

FILE: verif/tb_top.sv
module tb_top;
	import rpi_pkg::*;

	localparam int MAX_BKPT = 8;
	localparam int PIPE_LATENCY = 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PROFILE_LEN = 5;
	localparam int TEMP_CEIL = 8191;
	// Index with no register behind it; writes there must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Solder profile knees: time in 1/16 s, temperature in 1/16 C.
	// First and last knee of each profile sit at room temperature.
	localparam int KNEE_TIME [2][PROFILE_LEN] = '{
		'{0, 90 * 16, 165 * 16, 225 * 16, 270 * 16},
		'{0, 90 * 16, 180 * 16, 225 * 16, 270 * 16}
	};
	localparam int KNEE_TEMP [2][PROFILE_LEN] = '{
		'{0, 150 * 16, 175 * 16, 245 * 16, 0},
		'{0, 150 * 16, 180 * 16, 230 * 16, 0}
	};

	typedef struct {
		logic [15:0] elapsed;
		logic [12:0] temp;
		logic        done;
	} setpoint_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] elapsed_time
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [12:0] setpoint_temp, [15:13] zero
	logic        m_tuser;        // [0] profile_done
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [12:0] cfg_data = '0;

	// Register copies seen by the predictor
	logic [1:0]  cur_sel = SEL_MANUAL;
	logic [12:0] cur_manual = 13'd400;
	logic [12:0] cur_room = 13'd400;

	setpoint_t pending_setpoints[$];
	int        error_count = 0;
	int        cycle_count = 0;
	bit        tx_idle_on = 1'b0;
	bit        rx_idle_on = 1'b0;
	int        hold_req = 0;
	int        hold_cnt = 0;
	int        stall_cnt = 0;

	reflow_profile_interpolator #(
		.MAX_BREAKPOINTS(MAX_BKPT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic longint knee_temp(int prof, int idx);
		if (idx == 0 || idx == PROFILE_LEN - 1)
			return longint'(cur_room);
		return longint'(KNEE_TEMP[prof][idx]);
	endfunction

	function automatic logic [12:0] clamp_temp(longint v);
		if (v < 0)
			return 13'd0;
		if (v > TEMP_CEIL)
			return 13'(TEMP_CEIL);
		return 13'(v);
	endfunction

	// Setpoint for one time sample under the current register values
	function automatic setpoint_t predict_setpoint(logic [15:0] t);
		setpoint_t r;
		longint t0, den, y0, dy, num, n2, d2, q;
		int prof, last;
		bit hit;
		r.elapsed = t;
		r.temp = cur_room;
		r.done = 1'b1;
		hit = 1'b0;
		case (cur_sel)
			SEL_MANUAL: begin
				r.temp = cur_manual;
				r.done = 1'b0;
			end
			SEL_PROF1, SEL_PROF2: begin
				prof = (cur_sel == SEL_PROF1) ? 0 : 1;
				last = ((PROFILE_LEN < MAX_BKPT) ? PROFILE_LEN : MAX_BKPT) - 1;
				r.temp = clamp_temp(knee_temp(prof, last));
				for (int i = 1; i <= last && !hit; i++) begin
					if (int'(t) < KNEE_TIME[prof][i]) begin
						t0 = longint'(KNEE_TIME[prof][i - 1]);
						den = longint'(KNEE_TIME[prof][i]) - t0;
						if (den <= 0)
							den = 1;
						y0 = knee_temp(prof, i - 1);
						dy = knee_temp(prof, i) - y0;
						num = dy * (longint'(t) - t0);
						// round half up: floor((2*num + den) / (2*den))
						n2 = 2 * num + den;
						d2 = 2 * den;
						q = n2 / d2;
						if (n2 < 0 && (n2 % d2) != 0)
							q = q - 1;
						r.temp = clamp_temp(y0 + q);
						r.done = 1'b0;
						hit = 1'b1;
					end
				end
			end
			SEL_NONE: begin
				r.temp = cur_room;
				r.done = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [15:0] pick_time();
		int k, base;
		k = $urandom_range(0, 9);
		if (k < 2)
			return 16'($urandom_range(0, 65535));
		if (k < 4) begin
			// land near a knee of either profile
			base = KNEE_TIME[$urandom_range(0, 1)][$urandom_range(0, PROFILE_LEN - 1)];
			base = base + int'($urandom_range(0, 6)) - 3;
			return (base < 0) ? 16'd0 : 16'(base);
		end
		return 16'($urandom_range(0, 4600));
	endfunction

	function automatic logic [12:0] pick_temp();
		case ($urandom_range(0, 5))
			0: return 13'd0;
			1: return 13'(TEMP_CEIL);
			2: return 13'd400;
			default: return 13'($urandom_range(0, TEMP_CEIL));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [15:0] t, int got, int want);
		$display("MISMATCH %s at elapsed_time %0d: got %0d, want %0d", what, t, got, want);
		error_count++;
	endtask

	// Offer one time sample and record its setpoint once the transaction is taken
	task automatic send_sample(logic [15:0] t);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		pending_setpoints.push_back(predict_setpoint(t));
	endtask

	// Stop offering and let every outstanding setpoint come back
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_setpoints.size() != 0);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [12:0] value);
		wait_drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PROFILE_SELECT: cur_sel = value[1:0];
			REG_MANUAL_SETPOINT: cur_manual = value;
			REG_ROOM_TEMPERATURE: cur_room = value;
			default: ;
		endcase
	endtask

	// Drive the receiver's ready: long hold on request, random stalls when enabled
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_idle_on && $urandom_range(0, 5) == 0)
				stall_cnt = pick_gap();
		end
	end

	// Compare each result transaction with the oldest pending setpoint
	always @(posedge clk) begin
		setpoint_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_setpoints.size() == 0) begin
				report_mismatch("unexpected result", 16'd0, int'(m_tdata), -1);
			end else begin
				want = pending_setpoints.pop_front();
				if (m_tdata[12:0] !== want.temp)
					report_mismatch("setpoint_temp", want.elapsed, int'(m_tdata[12:0]),
						int'(want.temp));
				if (m_tuser !== want.done)
					report_mismatch("profile_done", want.elapsed, int'(m_tuser),
						int'(want.done));
				if (m_tdata[15:13] !== 3'd0)
					report_mismatch("tdata padding", want.elapsed, int'(m_tdata[15:13]), 0);
			end
		end
	end

	task automatic test_reset_values();
		send_sample(16'd0);
		send_sample(16'hFFFF);
	endtask

	task automatic test_manual_mode();
		cfg_write(REG_MANUAL_SETPOINT, 13'd0);
		send_sample(16'd1234);
		cfg_write(REG_MANUAL_SETPOINT, 13'(TEMP_CEIL));
		send_sample(16'd4320);
	endtask

	task automatic test_profile_breakpoints();
		// first profile, room at zero: each knee and both sides of the end
		cfg_write(REG_ROOM_TEMPERATURE, 13'd0);
		cfg_write(REG_PROFILE_SELECT, 13'(SEL_PROF1));
		send_sample(16'd0);
		send_sample(16'd1439);
		send_sample(16'd1440);
		send_sample(16'd2640);
		send_sample(16'd3600);
		send_sample(16'd4319);
		send_sample(16'd4320);
		send_sample(16'hFFFF);
		// second profile, room at full scale
		cfg_write(REG_ROOM_TEMPERATURE, 13'(TEMP_CEIL));
		cfg_write(REG_PROFILE_SELECT, 13'(SEL_PROF2));
		send_sample(16'd1);
		send_sample(16'd2879);
		send_sample(16'd2880);
		send_sample(16'd4319);
	endtask

	task automatic test_rounding_ties();
		// rising ramp landing exactly halfway: 400 + 2000*9/1440
		cfg_write(REG_PROFILE_SELECT, 13'(SEL_PROF1));
		cfg_write(REG_ROOM_TEMPERATURE, 13'd400);
		send_sample(16'd9);
		// falling ramp landing exactly halfway: tie must round up, not down
		cfg_write(REG_ROOM_TEMPERATURE, 13'd3560);
		send_sample(16'd3601);
	endtask

	task automatic test_invalid_selection();
		cfg_write(REG_PROFILE_SELECT, 13'(SEL_NONE));
		send_sample(16'd0);
		send_sample(16'd100);
		// write to the unused index and make sure nothing moved
		cfg_write(REG_UNUSED, 13'(TEMP_CEIL));
		send_sample(16'd2000);
	endtask

	task automatic test_backpressure();
		cfg_write(REG_PROFILE_SELECT, 13'(SEL_PROF2));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_req = 80;
		repeat (40) send_sample(pick_time());
		wait_drain();
	endtask

	task automatic test_random_phases();
		logic [1:0] sel;
		int k;
		for (int ph = 0; ph < 14; ph++) begin
			k = $urandom_range(0, 9);
			if (k == 0)
				sel = SEL_MANUAL;
			else if (k == 1)
				sel = SEL_NONE;
			else if (k < 6)
				sel = SEL_PROF1;
			else
				sel = SEL_PROF2;
			// upper data bits are don't-care for the selection register
			cfg_write(REG_PROFILE_SELECT, {11'($urandom_range(0, 2047)), sel});
			cfg_write(REG_MANUAL_SETPOINT, pick_temp());
			cfg_write(REG_ROOM_TEMPERATURE, pick_temp());
			if ($urandom_range(0, 3) == 0)
				cfg_write(REG_UNUSED, 13'($urandom_range(0, TEMP_CEIL)));
			// every third phase runs without idling on either side
			tx_idle_on = (ph % 3 != 0);
			rx_idle_on = (ph % 3 != 0);
			repeat (60) send_sample(pick_time());
			wait_drain();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_manual_mode();
		test_profile_breakpoints();
		test_rounding_ties();
		test_invalid_selection();
		test_backpressure();
		test_random_phases();

		wait_drain();
		repeat (PIPE_LATENCY * 2) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
